@@ rtl/sine_compressor_overdrive_defines.svh @@
// Assertion macros used by the checker file of the sine compressor overdrive block.
`ifndef SINE_COMPRESSOR_OVERDRIVE_DEFINES_SVH
`define SINE_COMPRESSOR_OVERDRIVE_DEFINES_SVH

// check a property on every rising clock edge outside reset
`define SCO_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// hold a signal and its valid while the condition stands
`define SCO_ASSERT_HOLD(lbl, clk, rst_n, cond, vld, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		(cond) |=> ((vld) && $stable(sig))) else $error(msg);

`endif

@@ rtl/scomp_pkg.sv @@
// Package with constants, types and table functions of the sine compressor overdrive block.
`default_nettype none
package scomp_pkg;

	localparam int PHASE_BITS_DEF = 32;
	localparam int SINE_ADDR_BITS_DEF = 10;
	localparam int TANH_ADDR_BITS_DEF = 10;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLUME = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DRIVE = 2'd2;

	localparam logic [31:0] PHASE_STEP_RST = 32'd42852280;
	localparam logic [11:0] VOLUME_RST = 12'd2048;
	localparam logic [11:0] DRIVE_RST = 12'd0;

	localparam logic [27:0] ATTACK_C = 28'd655;
	localparam logic [27:0] RELEASE_C = 28'd33;
	localparam logic [15:0] HALF_LEVEL = 16'd32768;
	localparam logic [16:0] UNITY_GAIN = 17'd65536;
	localparam logic [26:0] DRIVE_MUL = 27'd76;
	localparam logic [18:0] DRIVE_ROUND = 19'd2047;
	localparam logic [26:0] DRIVE_RECIP = 27'd524417;
	localparam logic [27:0] OUT_RECIP = 28'd134250505;
	localparam logic [15:0] KNOB_FULL = 16'd4095;
	localparam logic [18:0] DRIVE_BASE = 19'd16384;
	localparam logic [26:0] OUT_SCALE = 27'd30000;
	localparam logic [16:0] TANH_CLAMP = 17'd65536;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	typedef struct packed {
		logic [31:0] phase_step;
		logic [11:0] volume;
		logic [11:0] drive;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned abits);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] half;
		logic [63:0] quarter;
		logic [63:0] r;
		logic [63:0] j;
		logic [63:0] v;
		logic signed [63:0] sum;
		half = 64'd1 << (abits - 1);
		quarter = 64'd1 << (abits - 2);
		r = 64'(k) & (half - 64'd1);
		j = (r <= quarter) ? r : half - r;
		x = (j * HALF_PI_Q30) >> (abits - 2);
		term = x;
		sum = $signed(x);
		for (int n = 1; n <= 6; n++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = udiv64(term, 64'(2 * n) * 64'(2 * n + 1));
			if ((n & 1) == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > $signed(ONE_Q30)) begin
			sum = $signed(ONE_Q30);
		end
		v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (64'(k) >= half) begin
			v = -v;
		end
		return v[15:0];
	endfunction

	function automatic logic [14:0] tanh_entry(input int unsigned k, input int unsigned abits);
		logic [63:0] xq;
		logic [63:0] x2;
		logic [63:0] r;
		logic [63:0] t;
		xq = 64'(k) << (30 - abits);
		x2 = (xq * xq) >> 28;
		r = 64'd25 << 28;
		for (int i = 12; i > 0; i--) begin
			r = (64'(2 * (i - 1) + 1) << 28) + udiv64(x2 << 28, r);
		end
		t = udiv64(xq << 28, r);
		t = (t * 64'd32767 + (64'd1 << 27)) >> 28;
		if (t > 64'd32767) begin
			t = 64'd32767;
		end
		return t[14:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/scomp_if.sv @@
// Stream and configuration channel interfaces of the sine compressor overdrive block.
`default_nettype none
interface scomp_in_if;
	logic valid;
	logic ready;
	logic tick;
	modport source(output valid, output tick, input ready);
	modport sink(input valid, input tick, output ready);
endinterface

interface scomp_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] audio_sample;
	logic        [15:0] level;
	modport source(output valid, output audio_sample, output level, input ready);
	modport sink(input valid, input audio_sample, input level, output ready);
endinterface

interface scomp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [scomp_pkg::CFG_INDEX_W-1:0] index;
	logic [31:0]                      data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/scomp_tables.sv @@
// Sine and tanh lookup memories with registered read data.
`default_nettype none
module scomp_tables #(
	parameter int SINE_ADDR_BITS = scomp_pkg::SINE_ADDR_BITS_DEF,
	parameter int TANH_ADDR_BITS = scomp_pkg::TANH_ADDR_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic [SINE_ADDR_BITS-1:0] sine_addr,
	input  wire logic [TANH_ADDR_BITS:0]   tanh_addr,
	output logic signed [15:0]             sine_data,
	output logic [14:0]                    tanh_data
);
	localparam int SINE_DEPTH = 1 << SINE_ADDR_BITS;
	localparam int TANH_DEPTH = (1 << TANH_ADDR_BITS) + 1;

	typedef logic [15:0] sine_arr_t [SINE_DEPTH];
	typedef logic [14:0] tanh_arr_t [TANH_DEPTH];

	function automatic sine_arr_t build_sine();
		sine_arr_t r;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			r[k] = scomp_pkg::sine_entry(k, SINE_ADDR_BITS);
		end
		return r;
	endfunction

	function automatic tanh_arr_t build_tanh();
		tanh_arr_t r;
		for (int k = 0; k < TANH_DEPTH; k++) begin
			r[k] = scomp_pkg::tanh_entry(k, TANH_ADDR_BITS);
		end
		return r;
	endfunction

	localparam sine_arr_t SINE_ROM = build_sine();
	localparam tanh_arr_t TANH_ROM = build_tanh();

	always_ff @(posedge clk) begin
		sine_data <= $signed(SINE_ROM[sine_addr]);
		tanh_data <= TANH_ROM[tanh_addr];
	end
endmodule
`default_nettype wire

@@ rtl/scomp_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module scomp_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire scomp_pkg::div_req_t   req,
	output scomp_pkg::div_rsp_t        rsp
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] divisor_q;
	logic [16:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[31]};
	assign fits = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(trial - {1'b0, divisor_q}) : trial[15:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

@@ rtl/scomp_seq.sv @@
// Sequencer and datapath: oscillator, envelope, gain, drive, shaping and output scaling.
`default_nettype none
module scomp_seq #(
	parameter int PHASE_BITS = scomp_pkg::PHASE_BITS_DEF,
	parameter int SINE_ADDR_BITS = scomp_pkg::SINE_ADDR_BITS_DEF,
	parameter int TANH_ADDR_BITS = scomp_pkg::TANH_ADDR_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire scomp_pkg::cfg_t           cfg,
	input  wire logic                      in_valid,
	input  wire logic                      in_tick,
	output logic                           in_ready,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [15:0]             out_sample,
	output logic [15:0]                    out_level,
	output logic [SINE_ADDR_BITS-1:0]      sine_addr,
	output logic [TANH_ADDR_BITS:0]        tanh_addr,
	input  wire logic signed [15:0]        sine_data,
	input  wire logic [14:0]               tanh_data,
	output scomp_pkg::div_req_t            div_req,
	input  wire scomp_pkg::div_rsp_t       div_rsp
);
	localparam int TANH_SH = 16 - TANH_ADDR_BITS;
	localparam logic [17:0] TANH_HALF = 18'(1 << (TANH_SH - 1));
	localparam logic [17:0] TANH_MAX = 18'(1 << TANH_ADDR_BITS);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SIN  = 4'd1;
	localparam logic [3:0] ST_ENV  = 4'd2;
	localparam logic [3:0] ST_GDIV = 4'd3;
	localparam logic [3:0] ST_M1   = 4'd4;
	localparam logic [3:0] ST_M1W  = 4'd5;
	localparam logic [3:0] ST_DMUL = 4'd6;
	localparam logic [3:0] ST_DDIV = 4'd7;
	localparam logic [3:0] ST_UMUL = 4'd8;
	localparam logic [3:0] ST_U    = 4'd9;
	localparam logic [3:0] ST_TANH = 4'd10;
	localparam logic [3:0] ST_VMUL = 4'd11;
	localparam logic [3:0] ST_TMUL = 4'd12;
	localparam logic [3:0] ST_ODIV = 4'd13;
	localparam logic [3:0] ST_OUT  = 4'd14;

	logic [3:0]            state_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [15:0]           env_q;
	logic                  out_valid_q;
	logic signed [15:0]    sample_q;
	logic [15:0]           level_q;

	logic                  neg_q;
	logic                  up_q;
	logic [14:0]           m_q;
	logic [16:0]           gain_q;
	logic [17:0]           m3_q;
	logic [18:0]           drive_q14_q;
	logic [TANH_ADDR_BITS:0] tidx_q;
	logic [26:0]           vs_q;
	logic [14:0]           mag_q;
	logic [54:0]           prod_q;

	logic [26:0]           op_a;
	logic [27:0]           op_b;
	logic [14:0]           m_now;
	logic [15:0]           a_now;
	logic [15:0]           d_now;
	logic [15:0]           env_step;
	logic [15:0]           env_new;
	logic [15:0]           sq;
	logic [15:0]           m1;
	logic [19:0]           u_raw;
	logic [16:0]           u_clamp;
	logic [17:0]           idx_full;

	assign m_now = sine_data[15] ? 15'(-sine_data) : 15'(sine_data);
	assign a_now = {m_now, 1'b0};
	assign d_now = (a_now > env_q) ? a_now - env_q : env_q - a_now;
	assign env_step = 16'((prod_q[25:0] + 26'd32768) >> 16);
	assign env_new = up_q ? env_q + env_step : env_q - env_step;
	assign sq = scomp_pkg::HALF_LEVEL + ((env_new - scomp_pkg::HALF_LEVEL) >> 2);
	assign m1 = prod_q[31:16];
	assign u_raw = prod_q[35:16];
	assign u_clamp = (u_raw > 20'(scomp_pkg::TANH_CLAMP)) ? scomp_pkg::TANH_CLAMP : u_raw[16:0];
	assign idx_full = ({1'b0, u_clamp} + TANH_HALF) >> TANH_SH;

	assign in_ready = (state_q == ST_IDLE);
	assign sine_addr = phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS];
	assign tanh_addr = tidx_q;
	assign out_valid = out_valid_q;
	assign out_sample = sample_q;
	assign out_level = level_q;

	always_comb begin
		op_a = '0;
		op_b = '0;
		div_req.start = 1'b0;
		div_req.dividend = '0;
		div_req.divisor = scomp_pkg::KNOB_FULL;
		case (state_q)
			ST_SIN: begin
				op_a = 27'(d_now);
				op_b = (a_now > env_q) ? scomp_pkg::ATTACK_C : scomp_pkg::RELEASE_C;
			end
			ST_ENV: begin
				div_req.start = env_new > scomp_pkg::HALF_LEVEL;
				div_req.dividend = {sq, 16'd0};
				div_req.divisor = env_new;
			end
			ST_M1: begin
				op_a = 27'(gain_q);
				op_b = 28'(m_q);
			end
			ST_M1W: begin
				op_a = scomp_pkg::DRIVE_MUL;
				op_b = 28'(cfg.drive);
			end
			ST_DMUL: begin
				op_a = scomp_pkg::DRIVE_RECIP;
				op_b = 28'(prod_q[18:0]) + 28'(scomp_pkg::DRIVE_ROUND);
			end
			ST_UMUL: begin
				op_a = 27'(drive_q14_q);
				op_b = 28'(m3_q);
			end
			ST_U: begin
				op_a = scomp_pkg::OUT_SCALE;
				op_b = 28'(cfg.volume);
			end
			ST_VMUL: begin
				op_a = vs_q;
				op_b = 28'(tanh_data);
			end
			ST_TMUL: begin
				op_a = prod_q[41:15];
				op_b = scomp_pkg::OUT_RECIP;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			env_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_tick) begin
						phase_q <= phase_q + cfg.phase_step[31 -: PHASE_BITS];
						state_q <= ST_SIN;
					end
				end
				ST_SIN:  state_q <= ST_ENV;
				ST_ENV: begin
					env_q <= env_new;
					state_q <= (env_new > scomp_pkg::HALF_LEVEL) ? ST_GDIV : ST_M1;
				end
				ST_GDIV: begin
					if (div_rsp.done) begin
						state_q <= ST_M1;
					end
				end
				ST_M1:   state_q <= ST_M1W;
				ST_M1W:  state_q <= ST_DMUL;
				ST_DMUL: state_q <= ST_DDIV;
				ST_DDIV: state_q <= ST_UMUL;
				ST_UMUL: state_q <= ST_U;
				ST_U:    state_q <= ST_TANH;
				ST_TANH: state_q <= ST_VMUL;
				ST_VMUL: state_q <= ST_TMUL;
				ST_TMUL: state_q <= ST_ODIV;
				ST_ODIV: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 55'(op_a) * 55'(op_b);
		case (state_q)
			ST_SIN: begin
				neg_q <= sine_data[15];
				m_q <= m_now;
				up_q <= a_now > env_q;
			end
			ST_ENV: gain_q <= scomp_pkg::UNITY_GAIN;
			ST_GDIV: begin
				if (div_rsp.done) begin
					gain_q <= div_rsp.quotient[16:0];
				end
			end
			ST_M1W: m3_q <= 18'(m1) + {1'b0, m1, 1'b0};
			ST_DMUL: drive_q14_q <= scomp_pkg::DRIVE_BASE + prod_q[18:0];
			ST_DDIV: drive_q14_q <= drive_q14_q + 19'(prod_q[38:31]);
			ST_U: begin
				tidx_q <= (idx_full > TANH_MAX) ? TANH_MAX[TANH_ADDR_BITS:0]
					: idx_full[TANH_ADDR_BITS:0];
			end
			ST_TANH: vs_q <= prod_q[26:0];
			ST_ODIV: mag_q <= prod_q[53:39];
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					sample_q <= neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
					level_q <= env_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/sine_compressor_overdrive.sv @@
// Top level of the sine compressor overdrive block: configuration registers and channels.
//
//   channel  direction  request carries
//   in_ch    sink       tick
//   out_ch   source     audio_sample, level
//   cfg_ch   sink       index, data (phase_step, volume_code, drive_code)
//
// A request with tick set runs the sequence from ST_SIN to ST_OUT and gives one result; the
// block takes the next request only when it is back in ST_IDLE; above an envelope of one half
// the 32-step restoring divider for the gain is added to the sequence in ST_GDIV.
// A request with tick clear is accepted in ST_IDLE and gives no result.
// Reset clears oscillator phase and envelope and loads the register defaults.
// A result waiting on out_ch does not block the next request; only its final load waits.
`default_nettype none
module sine_compressor_overdrive #(
	parameter int PHASE_BITS = scomp_pkg::PHASE_BITS_DEF,
	parameter int SINE_ADDR_BITS = scomp_pkg::SINE_ADDR_BITS_DEF,
	parameter int TANH_ADDR_BITS = scomp_pkg::TANH_ADDR_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	scomp_in_if.sink  in_ch,
	scomp_out_if.source out_ch,
	scomp_cfg_if.sink cfg_ch
);
	scomp_pkg::cfg_t     cfg_q;
	scomp_pkg::div_req_t div_req;
	scomp_pkg::div_rsp_t div_rsp;
	logic [SINE_ADDR_BITS-1:0] sine_addr;
	logic [TANH_ADDR_BITS:0]   tanh_addr;
	logic signed [15:0]        sine_data;
	logic [14:0]               tanh_data;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= scomp_pkg::PHASE_STEP_RST;
			cfg_q.volume <= scomp_pkg::VOLUME_RST;
			cfg_q.drive <= scomp_pkg::DRIVE_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				scomp_pkg::REG_PHASE_STEP: cfg_q.phase_step <= cfg_ch.data;
				scomp_pkg::REG_VOLUME:     cfg_q.volume <= cfg_ch.data[11:0];
				scomp_pkg::REG_DRIVE:      cfg_q.drive <= cfg_ch.data[11:0];
				default: begin
				end
			endcase
		end
	end

	scomp_tables #(
		.SINE_ADDR_BITS(SINE_ADDR_BITS),
		.TANH_ADDR_BITS(TANH_ADDR_BITS)
	) u_tables (
		.clk(clk),
		.sine_addr(sine_addr),
		.tanh_addr(tanh_addr),
		.sine_data(sine_data),
		.tanh_data(tanh_data)
	);

	scomp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	scomp_seq #(
		.PHASE_BITS(PHASE_BITS),
		.SINE_ADDR_BITS(SINE_ADDR_BITS),
		.TANH_ADDR_BITS(TANH_ADDR_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_ch.valid),
		.in_tick(in_ch.tick),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_sample(out_ch.audio_sample),
		.out_level(out_ch.level),
		.sine_addr(sine_addr),
		.tanh_addr(tanh_addr),
		.sine_data(sine_data),
		.tanh_data(tanh_data),
		.div_req(div_req),
		.div_rsp(div_rsp)
	);
endmodule
`default_nettype wire

@@ rtl/scomp_checker.sv @@
// Port-level assertions of the sine compressor overdrive block and their bind.
`default_nettype none
`include "sine_compressor_overdrive_defines.svh"
module scomp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        in_tick,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] audio_sample,
	input wire logic [15:0] level
);
	`SCO_ASSERT(a_out_range, clk, arst_n, out_valid |-> ($signed(audio_sample) >= -16'sd30000 && $signed(audio_sample) <= 16'sd30000), "audio sample out of range")
	`SCO_ASSERT(a_busy_after_tick, clk, arst_n, (in_valid && in_ready && in_tick) |=> !in_ready, "ready after tick request")
	`SCO_ASSERT(a_idle_on_result, clk, arst_n, $rose(out_valid) |-> in_ready, "result issued while busy")
	`SCO_ASSERT_HOLD(a_sample_hold, clk, arst_n, out_valid && !out_ready, out_valid, audio_sample, "sample changed while stalled")
	`SCO_ASSERT_HOLD(a_level_hold, clk, arst_n, out_valid && !out_ready, out_valid, level, "level changed while stalled")
endmodule

bind sine_compressor_overdrive scomp_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.in_tick(in_ch.tick),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.audio_sample(out_ch.audio_sample),
	.level(out_ch.level)
);
`default_nettype wire
